// ===== src/msr_pkg.sv =====
// ----------------------------------------------------------------------------
// msr_pkg: shared definitions of the multi-axis stepper ramp
// Widths, reset values, action and register codes, and the command and
// status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package msr_pkg;

   localparam int AXES          = 3;
   localparam int AXIS_W        = (AXES > 1) ? $clog2(AXES) : 1;
   localparam int NUM_LIMITS    = 3;
   localparam int SLEEP_HOLD_MS = 10;

   localparam int POS_W   = 18;
   localparam int LIMIT_W = 17;
   localparam int CFG_W   = 17;
   localparam int CFG_IDX_W = 3;

   // Register indexes of the configuration port.
   localparam logic [CFG_IDX_W-1:0] CFG_INIT_DELAY = 3'd0;
   localparam logic [CFG_IDX_W-1:0] CFG_MIN_DELAY  = 3'd1;
   localparam logic [CFG_IDX_W-1:0] CFG_RAMP_MS    = 3'd2;
   localparam logic [CFG_IDX_W-1:0] CFG_ACCEL      = 3'd3;
   localparam logic [CFG_IDX_W-1:0] CFG_DECEL      = 3'd4;
   localparam logic [CFG_IDX_W-1:0] CFG_LIMIT0     = 3'd5;
   localparam logic [CFG_IDX_W-1:0] CFG_LIMIT1     = 3'd6;
   localparam logic [CFG_IDX_W-1:0] CFG_LIMIT2     = 3'd7;

   // Reset values of the registers.
   localparam logic [15:0] INIT_DELAY_RST = 16'd2000;
   localparam logic [14:0] INIT_DIV3_RST  = 15'd666;
   localparam logic [15:0] MIN_DELAY_RST  = 16'd200;
   localparam logic [7:0]  RAMP_MS_RST    = 8'd10;
   localparam logic [15:0] ACCEL_RST      = 16'd62415;
   localparam logic [16:0] DECEL_RST      = 17'd69641;
   localparam logic [16:0] LIMIT0_RST     = 17'd60000;
   localparam logic [16:0] LIMIT1_RST     = 17'd60000;
   localparam logic [16:0] LIMIT2_RST     = 17'd40000;

   // Division by three of a 16-bit value: (x * RECIP3) >> 17.
   localparam logic [16:0] RECIP3   = 17'd43691;
   localparam logic [9:0]  MS_TO_US = 10'd1000;

   typedef enum logic [1:0] {
      ACT_TICK  = 2'd0,
      ACT_WAKE  = 2'd1,
      ACT_SLEEP = 2'd2,
      ACT_LOAD  = 2'd3
   } action_type;

   typedef struct packed {
      logic              latch;
      logic              pins;
      logic              exec;
      logic              ramp_dist;
      logic              ramp_cmp;
      logic              ramp_apply;
      logic              axis_delay;
      logic              axis_step;
      logic              load_rsp;
      logic [AXIS_W-1:0] axis_sel;
   } cmd_type;

   typedef struct packed {
      action_type action;
      logic       all_asleep;
      logic       rsp_free;
   } status_type;

endpackage

// ===== src/msr_if.sv =====
// ----------------------------------------------------------------------------
// msr channels: request, response and register write channels
// Valid/ready channels; a transaction completes when both are high.
// ----------------------------------------------------------------------------
interface msr_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  action;
   logic [31:0] now_us;
   logic [31:0] now_ms;
   logic [1:0]  axis_index;
   logic signed [17:0] target_position;
   logic        move_down;
   logic [15:0] speed_ratio_q8;
   logic        is_lead;
   modport source (output valid, action, now_us, now_ms, axis_index, target_position,
                   move_down, speed_ratio_q8, is_lead, input ready);
   modport sink (input valid, action, now_us, now_ms, axis_index, target_position,
                 move_down, speed_ratio_q8, is_lead, output ready);
endinterface

interface msr_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  step_levels;
   logic [2:0]  sleep_pins;
   logic        all_asleep;
   logic [15:0] ramp_count;
   modport source (output valid, step_levels, sleep_pins, all_asleep, ramp_count,
                   input ready);
   modport sink (input valid, step_levels, sleep_pins, all_asleep, ramp_count,
                 output ready);
endinterface

interface msr_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [16:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== src/multi_axis_stepper_ramp.sv =====
// ----------------------------------------------------------------------------
// multi_axis_stepper_ramp: three-axis step pulse generator with shared ramp
// Top level joining the transaction sequencer and the stepper datapath.
// ----------------------------------------------------------------------------
// The req channel carries one transaction per command: a tick, a wake of all
// axes, a sleep of all axes, or a move load for one axis. Every request gives
// exactly one transaction on the rsp channel with the step line levels, the
// driver sleep pins, the all-asleep flag and the ramp step count as they stand
// after the command.
// A tick passes the sleep pin update, three ramp steps (distance, compare,
// Q16.16 multiply), two steps per axis (delay product, step) and the response
// load. The next request is taken once the sequencer is back in idle. A tick
// with every axis asleep and the other commands go from the dispatch straight
// to the response load. One request is in flight at a time.
// The user must have the csr channel write a register only while the block is
// idle; the block does not enforce this. The csr channel is always ready.
// Reset restores all register defaults, puts every axis to sleep with step
// line and sleep pin high and loads the multiplier from the initial delay.
// A stalled receiver holds the response; the next request may already be
// taken, and its result waits until the response register is free.
// ----------------------------------------------------------------------------
module multi_axis_stepper_ramp (
   input  logic      clock,
   input  logic      reset,
   msr_req_if.sink   req_bus,
   msr_rsp_if.source rsp_bus,
   msr_csr_if.sink   csr_bus
);

   msr_pkg::cmd_type    cmd;
   msr_pkg::status_type status;
   logic                req_ready;

   assign req_bus.ready = req_ready;

   // Sequencer that steps each transaction through the datapath.
   msr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Registers, arithmetic and the response register.
   msr_dp u_dp (
      .clock  (clock),
      .reset  (reset),
      .req    (req_bus),
      .rsp    (rsp_bus),
      .csr    (csr_bus),
      .cmd    (cmd),
      .status (status)
   );

   // Only one transaction is in flight: right after acceptance the
   // block is busy.
   assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_ready) |=> !req_ready)
      else $error("request accepted while a transaction is in flight");

   // All sleep pins raised imply that every axis is asleep.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.sleep_pins == 3'b111) |-> rsp_bus.all_asleep)
      else $error("all sleep pins high while an axis is awake");

   // A response is loaded only from the response state of the sequencer.
   assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> !req_ready)
      else $error("response loaded while idle");

endmodule

// ===== src/msr_ctrl.sv =====
// ----------------------------------------------------------------------------
// msr_ctrl: transaction sequencer
// Walks one request through pin update or command execution, ramp steps, per-axis steps and the response load.
// ----------------------------------------------------------------------------
module msr_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  msr_pkg::status_type status,
   output msr_pkg::cmd_type    cmd
);

   typedef enum logic [2:0] {
      S_IDLE, S_DISPATCH, S_RDIST, S_RCMP, S_RAPPLY, S_ADELAY, S_ASTEP, S_RESP
   } state_type;

   state_type                   state_ff, state_in;
   logic [msr_pkg::AXIS_W-1:0]  axis_ff, axis_in;

   always_comb begin
      state_in     = state_ff;
      axis_in      = axis_ff;
      cmd          = '0;
      cmd.axis_sel = axis_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            if (status.action == msr_pkg::ACT_TICK) begin
               cmd.pins = 1'b1;
               state_in = status.all_asleep ? S_RESP : S_RDIST;
            end else begin
               cmd.exec = 1'b1;
               state_in = S_RESP;
            end
         end
         S_RDIST: begin
            cmd.ramp_dist = 1'b1;
            state_in      = S_RCMP;
         end
         S_RCMP: begin
            cmd.ramp_cmp = 1'b1;
            state_in     = S_RAPPLY;
         end
         S_RAPPLY: begin
            cmd.ramp_apply = 1'b1;
            axis_in        = '0;
            state_in       = S_ADELAY;
         end
         S_ADELAY: begin
            cmd.axis_delay = 1'b1;
            state_in       = S_ASTEP;
         end
         S_ASTEP: begin
            cmd.axis_step = 1'b1;
            if (32'(axis_ff) == msr_pkg::AXES - 1) begin
               state_in = S_RESP;
            end else begin
               axis_in  = axis_ff + 1'b1;
               state_in = S_ADELAY;
            end
         end
         S_RESP: begin
            if (status.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign req_ready = (state_ff == S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         axis_ff  <= '0;
      end else begin
         state_ff <= state_in;
         axis_ff  <= axis_in;
      end
   end

endmodule

// ===== src/msr_dp.sv =====
// ----------------------------------------------------------------------------
// msr_dp: stepper datapath
// Registers, ramp arithmetic, per-axis stepping and the response register.
// ----------------------------------------------------------------------------
module msr_dp (
   input  logic                clock,
   input  logic                reset,
   msr_req_if.sink             req,
   msr_rsp_if.source           rsp,
   msr_csr_if.sink             csr,
   input  msr_pkg::cmd_type    cmd,
   output msr_pkg::status_type status
);

   localparam int A = msr_pkg::AXES;
   localparam int PW = msr_pkg::POS_W;

   // Configuration.
   logic [15:0] init_ff, min_ff, accel_ff;
   logic [14:0] div3_ff;
   logic [7:0]  period_ff;
   logic [16:0] decel_ff;
   logic [msr_pkg::LIMIT_W-1:0] limit_ff [msr_pkg::NUM_LIMITS];
   logic [32:0] div3_prod;

   // Ramp state.
   logic [31:0] mult_ff, last_ramp_ff;
   logic [15:0] steps_ff;
   logic [msr_pkg::AXIS_W-1:0] lead_ff;
   logic        due_ff, acc_ff, dec_ff;
   logic [33:0] lhs_ff;
   logic [23:0] rhs1_ff;

   // Axis state.
   logic signed [PW-1:0] pos_ff [A];
   logic signed [PW-1:0] tgt_ff [A];
   logic [15:0] ratio_ff [A];
   logic [31:0] delay_ff [A], last_us_ff [A], done_ff [A];
   logic [A-1:0] down_ff, asleep_ff, level_ff, pin_ff;

   // Latched request.
   msr_pkg::action_type act_ff;
   logic [31:0] now_us_ff, now_ms_ff;
   logic [1:0]  idx_ff;
   logic signed [PW-1:0] tpos_ff;
   logic        mdown_ff, lead_req_ff;
   logic [15:0] sratio_ff;

   logic        rsp_valid_ff;
   logic [2:0]  rsp_lv_ff, rsp_pv_ff;
   logic        rsp_all_ff;
   logic [15:0] rsp_cnt_ff;

   // Shared read port of the axis registers.
   logic [msr_pkg::AXIS_W-1:0] rd;
   logic signed [PW-1:0] rd_pos, rd_tgt, step_pos, new_tgt;
   logic signed [PW:0]   diff, pos_x, lim_x;
   logic [PW:0]          lead_dist;
   logic [msr_pkg::LIMIT_W-1:0] lim;
   logic [47:0] dly_prod;
   logic [33:0] lhs_prod, rhs;
   logic [23:0] rhs1_prod;
   logic [16:0] gain;
   logic [48:0] ramp_prod;
   logic [31:0] ramp_sat, elapsed_us;
   logic        stepping;

   assign rd     = (cmd.ramp_dist || cmd.ramp_cmp) ? lead_ff : cmd.axis_sel;
   assign rd_pos = pos_ff[rd];
   assign rd_tgt = tgt_ff[rd];
   assign lim    = (32'(rd) < msr_pkg::NUM_LIMITS) ? limit_ff[rd]
                                                   : limit_ff[msr_pkg::NUM_LIMITS-1];

   assign diff      = {rd_tgt[PW-1], rd_tgt} - {rd_pos[PW-1], rd_pos};
   assign lead_dist = diff[PW] ? PW'(0) - diff : diff;
   assign lhs_prod  = div3_ff * lead_dist;
   assign rhs1_prod = steps_ff * period_ff;
   assign rhs       = rhs1_ff * msr_pkg::MS_TO_US;

   assign gain      = acc_ff ? {1'b0, accel_ff} : decel_ff;
   assign ramp_prod = mult_ff * gain;
   assign ramp_sat  = ramp_prod[48] ? 32'hFFFF_FFFF : ramp_prod[47:16];

   assign dly_prod   = ratio_ff[rd] * mult_ff;
   assign elapsed_us = now_us_ff - last_us_ff[rd];
   assign stepping   = (elapsed_us >= delay_ff[rd]) && (rd_pos != rd_tgt);
   assign step_pos   = down_ff[rd] ? rd_pos - 1'b1 : rd_pos + 1'b1;
   assign pos_x      = {step_pos[PW-1], step_pos};
   assign lim_x      = {2'b00, lim};
   assign new_tgt    = (stepping && (pos_x <= -lim_x || pos_x >= lim_x)) ? step_pos : rd_tgt;

   assign div3_prod = csr.data[15:0] * msr_pkg::RECIP3;

   assign csr.ready         = 1'b1;
   assign status.action     = act_ff;
   assign status.all_asleep = &asleep_ff;
   assign status.rsp_free   = !rsp_valid_ff || rsp.ready;

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.step_levels = rsp_lv_ff;
   assign rsp.sleep_pins  = rsp_pv_ff;
   assign rsp.all_asleep  = rsp_all_ff;
   assign rsp.ramp_count  = rsp_cnt_ff;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         init_ff     <= msr_pkg::INIT_DELAY_RST;
         div3_ff     <= msr_pkg::INIT_DIV3_RST;
         min_ff      <= msr_pkg::MIN_DELAY_RST;
         period_ff   <= msr_pkg::RAMP_MS_RST;
         accel_ff    <= msr_pkg::ACCEL_RST;
         decel_ff    <= msr_pkg::DECEL_RST;
         limit_ff[0] <= msr_pkg::LIMIT0_RST;
         limit_ff[1] <= msr_pkg::LIMIT1_RST;
         limit_ff[2] <= msr_pkg::LIMIT2_RST;
      end else if (csr.valid) begin
         case (csr.index)
            msr_pkg::CFG_INIT_DELAY: begin
               init_ff <= csr.data[15:0];
               div3_ff <= div3_prod[31:17];
            end
            msr_pkg::CFG_MIN_DELAY: min_ff      <= csr.data[15:0];
            msr_pkg::CFG_RAMP_MS:   period_ff   <= csr.data[7:0];
            msr_pkg::CFG_ACCEL:     accel_ff    <= csr.data[15:0];
            msr_pkg::CFG_DECEL:     decel_ff    <= csr.data;
            msr_pkg::CFG_LIMIT0:    limit_ff[0] <= csr.data;
            msr_pkg::CFG_LIMIT1:    limit_ff[1] <= csr.data;
            msr_pkg::CFG_LIMIT2:    limit_ff[2] <= csr.data;
            default: begin
            end
         endcase
      end
   end

   // Request capture and the ramp distance products.
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         act_ff      <= msr_pkg::action_type'(req.action);
         now_us_ff   <= req.now_us;
         now_ms_ff   <= req.now_ms;
         idx_ff      <= req.axis_index;
         tpos_ff     <= req.target_position;
         mdown_ff    <= req.move_down;
         sratio_ff   <= req.speed_ratio_q8;
         lead_req_ff <= req.is_lead;
      end
      if (cmd.ramp_dist) begin
         lhs_ff  <= lhs_prod;
         rhs1_ff <= rhs1_prod;
      end
   end

   // Ramp and axis state.
   always_ff @(posedge clock) begin
      if (reset) begin
         mult_ff      <= {msr_pkg::INIT_DELAY_RST, 16'h0000};
         steps_ff     <= '0;
         last_ramp_ff <= '0;
         lead_ff      <= '0;
         due_ff       <= 1'b0;
         acc_ff       <= 1'b0;
         dec_ff       <= 1'b0;
         down_ff      <= '0;
         asleep_ff    <= '1;
         level_ff     <= '1;
         pin_ff       <= '1;
         for (int i = 0; i < A; i++) begin
            pos_ff[i]     <= '0;
            tgt_ff[i]     <= '0;
            ratio_ff[i]   <= '0;
            delay_ff[i]   <= '0;
            last_us_ff[i] <= '0;
            done_ff[i]    <= '0;
         end
      end else begin
         if (cmd.pins) begin
            for (int i = 0; i < A; i++) begin
               if (asleep_ff[i] && !pin_ff[i] &&
                   (now_ms_ff - done_ff[i]) > 32'(msr_pkg::SLEEP_HOLD_MS)) begin
                  pin_ff[i] <= 1'b1;
               end
            end
         end
         if (cmd.exec) begin
            case (act_ff)
               msr_pkg::ACT_WAKE: begin
                  asleep_ff    <= '0;
                  pin_ff       <= '0;
                  last_ramp_ff <= now_ms_ff - {24'h0, period_ff} - 32'd1;
                  mult_ff      <= {init_ff, 16'h0000};
                  steps_ff     <= '0;
               end
               msr_pkg::ACT_SLEEP: begin
                  asleep_ff <= '1;
                  for (int i = 0; i < A; i++) begin
                     done_ff[i] <= now_ms_ff;
                  end
               end
               msr_pkg::ACT_LOAD: begin
                  if (32'(idx_ff) < A) begin
                     tgt_ff[idx_ff[msr_pkg::AXIS_W-1:0]]   <= tpos_ff;
                     down_ff[idx_ff[msr_pkg::AXIS_W-1:0]]  <= mdown_ff;
                     ratio_ff[idx_ff[msr_pkg::AXIS_W-1:0]] <= sratio_ff;
                     if (lead_req_ff) begin
                        lead_ff <= idx_ff[msr_pkg::AXIS_W-1:0];
                     end
                  end
               end
               default: begin
               end
            endcase
         end
         if (cmd.ramp_dist) begin
            due_ff <= (now_ms_ff - last_ramp_ff) >= {24'h0, period_ff};
            if ((now_ms_ff - last_ramp_ff) >= {24'h0, period_ff}) begin
               last_ramp_ff <= last_ramp_ff + {24'h0, period_ff};
            end
         end
         if (cmd.ramp_cmp) begin
            acc_ff <= due_ff && (lhs_ff >= rhs) && (delay_ff[rd] > {16'h0, min_ff}) &&
                      (steps_ff != 16'hFFFF);
            dec_ff <= due_ff && (lhs_ff < rhs) && (steps_ff != 16'h0000);
         end
         if (cmd.ramp_apply) begin
            if (acc_ff) begin
               mult_ff  <= ramp_sat;
               steps_ff <= steps_ff + 16'd1;
            end else if (dec_ff) begin
               steps_ff <= steps_ff - 16'd1;
               mult_ff  <= (steps_ff == 16'd1) ? {init_ff, 16'h0000} : ramp_sat;
            end
         end
         if (cmd.axis_delay) begin
            delay_ff[rd] <= {8'h00, dly_prod[47:24]};
         end
         if (cmd.axis_step && !asleep_ff[rd]) begin
            if (stepping) begin
               last_us_ff[rd] <= now_us_ff;
               level_ff[rd]   <= !level_ff[rd];
               pos_ff[rd]     <= step_pos;
               tgt_ff[rd]     <= new_tgt;
            end
            if ((stepping ? step_pos : rd_pos) == new_tgt) begin
               asleep_ff[rd] <= 1'b1;
               done_ff[rd]   <= now_ms_ff;
            end
         end
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_lv_ff  <= level_ff[2:0];
         rsp_pv_ff  <= pin_ff[2:0];
         rsp_all_ff <= &asleep_ff;
         rsp_cnt_ff <= steps_ff;
      end
   end

endmodule

// ===== dv/tb_msr_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_msr_if: testbench copy point for the channel interfaces
// The channels themselves come from the RTL; this file holds the command and
// status transaction records used by the stimulus and the checker.
// ----------------------------------------------------------------------------
package tb_msr_pkg;

   typedef struct {
      msr_pkg::action_type action;
      logic [31:0]        now_us;
      logic [31:0]        now_ms;
      logic [1:0]         axis_index;
      logic signed [17:0] target_position;
      logic               move_down;
      logic [15:0]        speed_ratio_q8;
      logic               is_lead;
   } move_cmd_type;

   typedef struct {
      logic [2:0]  step_levels;
      logic [2:0]  sleep_pins;
      logic        all_asleep;
      logic [15:0] ramp_count;
   } axis_status_type;
endpackage

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench of the multi-axis stepper ramp
// Drives ticks, wake, sleep, move loads and register writes, predicts every status
// response with a cycle-free model of the ramp and the axes, and compares in order.
// ----------------------------------------------------------------------------
module tb_top;

   logic clock = 1'b0;
   logic reset = 1'b1;

   msr_req_if req_bus ();
   msr_rsp_if rsp_bus ();
   msr_csr_if csr_bus ();

   multi_axis_stepper_ramp dut (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus.sink),
      .rsp_bus(rsp_bus.source),
      .csr_bus(csr_bus.sink)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Model copy of the configuration registers.
   logic [15:0] cfg_init_delay, cfg_min_delay, cfg_accel;
   logic [7:0]  cfg_ramp_ms;
   logic [16:0] cfg_decel;
   logic [16:0] cfg_limit [3];

   // Model copy of the ramp and axis state.
   logic [31:0]        mult_q16;
   logic [15:0]        ramp_steps;
   logic [31:0]        last_ramp_ms;
   logic [1:0]         lead;
   logic signed [17:0] pos [3];
   logic signed [17:0] tgt [3];
   logic               down [3];
   logic [15:0]        ratio [3];
   logic [31:0]        adelay [3];
   logic [31:0]        last_us [3];
   logic [31:0]        done_ms [3];
   logic               asleep [3], level [3], pin [3];

   tb_msr_pkg::axis_status_type expected_status [$];
   int  error_count = 0;
   int  idle_pct_src = 0;
   int  idle_pct_snk = 0;
   int  quiet_cycles = 0;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // Q16.16 gain scaling with saturation to 32 bits.
   function automatic logic [31:0] scale_gain(input logic [31:0] m, input logic [16:0] g);
      logic [63:0] p;
      p = ({32'd0, m} * {47'd0, g}) >> 16;
      return (p > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : p[31:0];
   endfunction

   function automatic logic [31:0] axis_delay_of(input int i);
      logic [63:0] p;
      p = {48'd0, ratio[i]} * {32'd0, mult_q16};
      return p[55:24];
   endfunction

   function automatic bit every_axis_asleep();
      return asleep[0] && asleep[1] && asleep[2];
   endfunction

   task automatic reset_model();
      cfg_init_delay = 16'd2000; cfg_min_delay = 16'd200; cfg_ramp_ms = 8'd10;
      cfg_accel = 16'd62415; cfg_decel = 17'd69641;
      cfg_limit[0] = 17'd60000; cfg_limit[1] = 17'd60000; cfg_limit[2] = 17'd40000;
      mult_q16 = {cfg_init_delay, 16'd0};
      ramp_steps = '0; last_ramp_ms = '0; lead = '0;
      for (int i = 0; i < 3; i++) begin
         pos[i] = '0; tgt[i] = '0; down[i] = 0; ratio[i] = '0; adelay[i] = '0;
         last_us[i] = '0; done_ms[i] = '0;
         asleep[i] = 1; level[i] = 1; pin[i] = 1;
      end
   endtask

   // Shared ramp update, at most once per ramp period.
   task automatic update_ramp(input logic [31:0] now_ms);
      int ld;
      logic signed [18:0] diff;
      logic [63:0] lead_dist, lhs, rhs;
      ld = (lead < 3) ? lead : 0;
      if ((now_ms - last_ramp_ms) < {24'd0, cfg_ramp_ms}) return;
      last_ramp_ms = last_ramp_ms + cfg_ramp_ms;
      diff = tgt[ld] - pos[ld];
      lead_dist = (diff < 0) ? -diff : diff;
      lhs = (cfg_init_delay / 3) * lead_dist;
      rhs = ramp_steps * cfg_ramp_ms * 64'd1000;
      if (lhs >= rhs) begin
         if (adelay[ld] > cfg_min_delay && ramp_steps < 16'hFFFF) begin
            mult_q16 = scale_gain(mult_q16, {1'b0, cfg_accel});
            ramp_steps++;
         end
      end else if (ramp_steps > 0) begin
         mult_q16 = scale_gain(mult_q16, cfg_decel);
         ramp_steps--;
         if (ramp_steps == 0) mult_q16 = {cfg_init_delay, 16'd0};
      end
   endtask

   task automatic step_axis(input int i, input logic [31:0] now_us, input logic [31:0] now_ms);
      logic signed [18:0] lim;
      lim = $signed({2'b0, cfg_limit[i]});
      adelay[i] = axis_delay_of(i);
      if ((now_us - last_us[i]) >= adelay[i] && pos[i] != tgt[i]) begin
         last_us[i] = now_us;
         level[i] = !level[i];
         pos[i] = down[i] ? pos[i] - 18'sd1 : pos[i] + 18'sd1;
         if (pos[i] <= -lim || pos[i] >= lim) tgt[i] = pos[i];
      end
      if (pos[i] == tgt[i]) begin
         asleep[i] = 1;
         done_ms[i] = now_ms;
      end
   endtask

   // Applies one command to the model and queues the status it leads to.
   task automatic predict_status(input tb_msr_pkg::move_cmd_type c);
      tb_msr_pkg::axis_status_type s;
      bit idle;
      case (c.action)
         msr_pkg::ACT_TICK: begin
            idle = every_axis_asleep();
            for (int i = 0; i < 3; i++)
               if (asleep[i] && !pin[i] && (c.now_ms - done_ms[i]) > msr_pkg::SLEEP_HOLD_MS)
                  pin[i] = 1;
            if (!idle) begin
               update_ramp(c.now_ms);
               for (int i = 0; i < 3; i++)
                  if (!asleep[i]) step_axis(i, c.now_us, c.now_ms);
                  else adelay[i] = axis_delay_of(i);
            end
         end
         msr_pkg::ACT_WAKE: begin
            for (int i = 0; i < 3; i++) begin
               asleep[i] = 0; pin[i] = 0;
            end
            last_ramp_ms = c.now_ms - cfg_ramp_ms - 32'd1;
            mult_q16 = {cfg_init_delay, 16'd0};
            ramp_steps = '0;
         end
         msr_pkg::ACT_SLEEP: begin
            for (int i = 0; i < 3; i++) begin
               asleep[i] = 1; done_ms[i] = c.now_ms;
            end
         end
         default: begin
            if (c.axis_index < 3) begin
               tgt[c.axis_index] = c.target_position;
               down[c.axis_index] = c.move_down;
               ratio[c.axis_index] = c.speed_ratio_q8;
               if (c.is_lead) lead = c.axis_index;
            end
         end
      endcase
      s.step_levels = {level[2], level[1], level[0]};
      s.sleep_pins = {pin[2], pin[1], pin[0]};
      s.all_asleep = every_axis_asleep();
      s.ramp_count = ramp_steps;
      expected_status.push_back(s);
   endtask

   // Response checker and receiver stalls.
   always @(posedge clock) begin
      tb_msr_pkg::axis_status_type w;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_status.size() == 0) begin
            report_mismatch("unexpected response", 0, 0);
         end else begin
            w = expected_status.pop_front();
            if (rsp_bus.step_levels !== w.step_levels)
               report_mismatch("step_levels", rsp_bus.step_levels, w.step_levels);
            if (rsp_bus.sleep_pins !== w.sleep_pins)
               report_mismatch("sleep_pins", rsp_bus.sleep_pins, w.sleep_pins);
            if (rsp_bus.all_asleep !== w.all_asleep)
               report_mismatch("all_asleep", rsp_bus.all_asleep, w.all_asleep);
            if (rsp_bus.ramp_count !== w.ramp_count)
               report_mismatch("ramp_count", rsp_bus.ramp_count, w.ramp_count);
         end
      end
   end

   always @(negedge clock)
      rsp_bus.ready <= ($urandom_range(99) >= idle_pct_snk);

   // Watchdog: counts cycles without any transaction on any channel.
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 5000) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // Simulated time base: microsecond and millisecond clocks move forward.
   logic [31:0] sim_us, sim_ms;

   task automatic send_command(input tb_msr_pkg::move_cmd_type c);
      @(negedge clock);
      while ($urandom_range(99) < idle_pct_src) @(negedge clock);
      req_bus.action <= c.action;
      req_bus.now_us <= c.now_us;
      req_bus.now_ms <= c.now_ms;
      req_bus.axis_index <= c.axis_index;
      req_bus.target_position <= c.target_position;
      req_bus.move_down <= c.move_down;
      req_bus.speed_ratio_q8 <= c.speed_ratio_q8;
      req_bus.is_lead <= c.is_lead;
      req_bus.valid <= 1'b1;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      predict_status(c);
      @(negedge clock);
      req_bus.valid <= 1'b0;
   endtask

   function automatic tb_msr_pkg::move_cmd_type make_cmd(input msr_pkg::action_type a);
      tb_msr_pkg::move_cmd_type c;
      c.action = a; c.now_us = sim_us; c.now_ms = sim_ms;
      c.axis_index = 2'($urandom_range(2)); c.target_position = 18'($urandom);
      c.move_down = 1'($urandom); c.speed_ratio_q8 = 16'($urandom);
      c.is_lead = 1'($urandom);
      return c;
   endfunction

   task automatic send_load(input int ax, input logic signed [17:0] t, input bit dn,
                            input logic [15:0] r, input bit ld);
      tb_msr_pkg::move_cmd_type c;
      c = make_cmd(msr_pkg::ACT_LOAD);
      c.axis_index = 2'(ax); c.target_position = t; c.move_down = dn;
      c.speed_ratio_q8 = r; c.is_lead = ld;
      send_command(c);
   endtask

   task automatic send_tick(input int dus, input int dms);
      sim_us = sim_us + dus; sim_ms = sim_ms + dms;
      send_command(make_cmd(msr_pkg::ACT_TICK));
   endtask

   // Waits for all responses, then lets the block settle before a write.
   task automatic drain();
      while (expected_status.size() != 0) @(negedge clock);
      repeat (30) @(negedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [16:0] v);
      @(negedge clock);
      csr_bus.index <= idx; csr_bus.data <= v; csr_bus.valid <= 1'b1;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      case (idx)
         msr_pkg::CFG_INIT_DELAY: cfg_init_delay = v[15:0];
         msr_pkg::CFG_MIN_DELAY:  cfg_min_delay = v[15:0];
         msr_pkg::CFG_RAMP_MS:    cfg_ramp_ms = v[7:0];
         msr_pkg::CFG_ACCEL:      cfg_accel = v[15:0];
         msr_pkg::CFG_DECEL:      cfg_decel = v;
         msr_pkg::CFG_LIMIT0:     cfg_limit[0] = v;
         msr_pkg::CFG_LIMIT1:     cfg_limit[1] = v;
         default:                 cfg_limit[2] = v;
      endcase
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   // Directed: wraps, limits, every command, pin hold and the all-asleep tick.
   task automatic test_directed();
      send_tick(5, 1);                               // all asleep, nothing moves
      send_load(0, 18'sd40, 0, 16'h0001, 1);
      send_load(1, -18'sd131071, 1, 16'hFFFF, 0);
      send_load(2, 18'sd131071, 0, 16'h0000, 0);
      send_load(3, 18'sd7, 1, 16'h1234, 1);          // out-of-range axis ignored
      send_command(make_cmd(msr_pkg::ACT_WAKE));
      for (int k = 0; k < 8; k++) send_tick(4000, 11);
      send_command(make_cmd(msr_pkg::ACT_SLEEP));
      send_tick(1, 5);                               // hold not yet expired
      send_tick(1, 6);                               // pins rise
      sim_us = 32'hFFFF_FFF0; sim_ms = 32'hFFFF_FFF8;  // clock wrap
      send_command(make_cmd(msr_pkg::ACT_WAKE));
      for (int k = 0; k < 6; k++) send_tick(9, 3);
      send_command(make_cmd(msr_pkg::ACT_SLEEP));
   endtask

   // Random: mostly load/wake/tick runs, some noise.
   task automatic test_random(input int n);
      int dus;
      for (int k = 0; k < n; k++) begin
         case ($urandom_range(9))
            0: send_command(make_cmd(msr_pkg::action_type'($urandom_range(3))));
            1: send_command(make_cmd(msr_pkg::ACT_WAKE));
            2: send_command(make_cmd(msr_pkg::ACT_SLEEP));
            3: begin
               if ($urandom_range(1))
                  send_load($urandom_range(2), 18'($signed($urandom_range(400)) - 200),
                            $urandom_range(1), 16'($urandom_range(512)),
                            $urandom_range(1));
               else
                  send_command(make_cmd(msr_pkg::ACT_LOAD));
            end
            default: begin
               dus = ($urandom_range(3) == 0) ? $urandom : $urandom_range(3000);
               send_tick(dus, $urandom_range(25));
            end
         endcase
      end
   endtask

   task automatic test_phase(input int src, input int snk, input int n);
      idle_pct_src = src; idle_pct_snk = snk;
      test_random(n);
   endtask

   task automatic test_config_sweep(input bit extreme_low);
      drain();
      write_reg(msr_pkg::CFG_INIT_DELAY, extreme_low ? 17'd1 : 17'd65535);
      write_reg(msr_pkg::CFG_MIN_DELAY, extreme_low ? 17'd1 : 17'd65535);
      write_reg(msr_pkg::CFG_RAMP_MS, extreme_low ? 17'd1 : 17'd255);
      write_reg(msr_pkg::CFG_ACCEL, extreme_low ? 17'd0 : 17'd65535);
      write_reg(msr_pkg::CFG_DECEL, extreme_low ? 17'd65536 : 17'd131071);
      write_reg(msr_pkg::CFG_LIMIT0, extreme_low ? 17'd1 : 17'd131071);
      write_reg(msr_pkg::CFG_LIMIT1, extreme_low ? 17'd50 : 17'd131071);
      write_reg(msr_pkg::CFG_LIMIT2, extreme_low ? 17'd100 : 17'd131071);
   endtask

   initial begin
      req_bus.valid = 0; req_bus.action = msr_pkg::ACT_TICK; req_bus.now_us = 0;
      req_bus.now_ms = 0; req_bus.axis_index = 0; req_bus.target_position = 0;
      req_bus.move_down = 0; req_bus.speed_ratio_q8 = 0; req_bus.is_lead = 0;
      rsp_bus.ready = 1; csr_bus.valid = 0; csr_bus.index = '0; csr_bus.data = '0;
      sim_us = 0; sim_ms = 0;
      reset_model();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_phase(0, 0, 200);
      test_phase(53, 0, 150);
      test_config_sweep(1);
      test_phase(0, 53, 150);
      test_config_sweep(0);
      test_phase(10, 10, 150);
      drain();
      write_reg(msr_pkg::CFG_INIT_DELAY, 17'd300);
      write_reg(msr_pkg::CFG_MIN_DELAY, 17'd20);
      write_reg(msr_pkg::CFG_RAMP_MS, 17'd2);
      write_reg(msr_pkg::CFG_ACCEL, 17'd50000);
      write_reg(msr_pkg::CFG_DECEL, 17'd80000);
      write_reg(msr_pkg::CFG_LIMIT0, 17'd150);
      write_reg(msr_pkg::CFG_LIMIT1, 17'd60000);
      write_reg(msr_pkg::CFG_LIMIT2, 17'd150);
      test_phase(0, 0, 230);

      drain();
      if (error_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end
endmodule

// ===== filelist.f =====
src/msr_pkg.sv
src/msr_if.sv
src/msr_ctrl.sv
src/msr_dp.sv
src/multi_axis_stepper_ramp.sv
dv/tb_msr_if.sv
dv/tb_top.sv
